### hw/rtl/ims_pkg.sv
package ims_pkg;

	localparam int ThrW = 16;
	localparam int MagW = 10;
	localparam int CfgIdxW = 1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_THR_DE4 = 1'b0,
		REG_THR_DE8 = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	// Spins of the current site and its four wrapped neighbors, plus the raster end mark.
	typedef struct packed {
		logic cur;
		logic up;
		logic down;
		logic left;
		logic right;
		logic last;
	} site_t;

endpackage

### hw/rtl/ims_if.sv
interface ims_item_if;
	import ims_pkg::*;
	logic            valid;
	logic            ready;
	logic            op;
	logic            spin_in;
	logic [ThrW-1:0] random_value;

	modport source (output valid, output op, output spin_in, output random_value, input ready);
	modport sink   (input valid, input op, input spin_in, input random_value, output ready);
endinterface

interface ims_result_if;
	import ims_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   spin_out;
	logic                   flipped;
	logic signed [MagW-1:0] magnetization;
	logic                   sweep_done;

	modport source (output valid, output spin_out, output flipped, output magnetization,
		output sweep_done, input ready);
	modport sink   (input valid, input spin_out, input flipped, input magnetization,
		input sweep_done, output ready);
endinterface

interface ims_cfg_if;
	import ims_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [ThrW-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/ims_lattice.sv
module ims_lattice
	import ims_pkg::*;
#(
	parameter int SIDE = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  logic  new_spin,
	output site_t site
);

	localparam int Sites = SIDE * SIDE;
	localparam int SideW = $clog2(SIDE);
	localparam logic [SideW-1:0] LastPos = SideW'(SIDE - 1);

	// The lattice rotates by one site per step, so the current site always sits
	// at position 0; up and down are fixed taps, left and right pick a tap by column.
	logic [Sites-1:0] grid_q;
	logic [SideW-1:0] col_q;
	logic [SideW-1:0] row_q;
	logic             col_first;
	logic             col_last;

	assign col_first = (col_q == '0);
	assign col_last  = (col_q == LastPos);

	assign site.cur   = grid_q[0];
	assign site.up    = grid_q[Sites-SIDE];
	assign site.down  = grid_q[SIDE];
	assign site.left  = col_first ? grid_q[SIDE-1] : grid_q[Sites-1];
	assign site.right = col_last ? grid_q[Sites-SIDE+1] : grid_q[1];
	assign site.last  = col_last && (row_q == LastPos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (step) begin
			grid_q <= {new_spin, grid_q[Sites-1:1]};
			if (col_last) begin
				col_q <= '0;
				row_q <= (row_q == LastPos) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

### hw/rtl/ims_decide.sv
module ims_decide
	import ims_pkg::*;
(
	input  site_t           site,
	input  logic            op,
	input  logic            spin_in,
	input  logic [ThrW-1:0] random_value,
	input  logic [ThrW-1:0] thr_de4,
	input  logic [ThrW-1:0] thr_de8,
	output logic            new_spin,
	output logic            flip
);

	logic [2:0] aligned;

	// The energy change is four times the number of neighbors that agree with the
	// spin, minus eight.
	assign aligned = 3'(site.up == site.cur) + 3'(site.down == site.cur)
		+ 3'(site.left == site.cur) + 3'(site.right == site.cur);

	always_comb begin
		flip = 1'b0;
		if (op == OP_UPDATE) begin
			case (aligned)
				3'd3:    flip = random_value < thr_de4;
				3'd4:    flip = random_value < thr_de8;
				default: flip = 1'b1;
			endcase
		end
		new_spin = (op == OP_LOAD) ? spin_in : (site.cur ^ flip);
	end

endmodule

### hw/rtl/ising_metropolis_sweep.sv
// An accepted request is held in the input register, then moves to the output
// register that drives the result. Throughput: one request per cycle unless a
// held result stalls it; the lattice rotates through flip-flops, so each site
// reads its neighbors and is written back in the same cycle.
// Reset: all spins -1, raster at site (0,0), thresholds 22 and 0, outputs idle.
module ising_metropolis_sweep
	import ims_pkg::*;
#(
	parameter int SIDE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	ims_item_if.sink            item,
	ims_result_if.source        result,
	ims_cfg_if.sink             cfg
);

	localparam int Sites = SIDE * SIDE;
	localparam logic [MagW-1:0] TotalReset = MagW'(-Sites);

	logic            valid_s1;
	logic            op_s1;
	logic            spin_in_s1;
	logic [ThrW-1:0] random_s1;
	logic            adv_s1;

	logic [ThrW-1:0] thr_de4_q;
	logic [ThrW-1:0] thr_de8_q;
	logic [MagW-1:0] total_q;
	logic [MagW-1:0] total_next;

	logic                   valid_s2;
	logic                   spin_s2;
	logic                   flip_s2;
	logic signed [MagW-1:0] mag_s2;
	logic                   done_s2;

	site_t site;
	logic  new_spin;
	logic  flip;

	assign adv_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv_s1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_de4_q <= ThrW'(22);
			thr_de8_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_THR_DE4: thr_de4_q <= cfg.data;
				REG_THR_DE8: thr_de8_q <= cfg.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1      <= item.op;
			spin_in_s1 <= item.spin_in;
			random_s1  <= item.random_value;
		end
	end

	ims_lattice #(
		.SIDE(SIDE)
	) u_lattice (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.new_spin(new_spin),
		.site    (site)
	);

	ims_decide u_decide (
		.site        (site),
		.op          (op_s1),
		.spin_in     (spin_in_s1),
		.random_value(random_s1),
		.thr_de4     (thr_de4_q),
		.thr_de8     (thr_de8_q),
		.new_spin    (new_spin),
		.flip        (flip)
	);

	always_comb begin
		total_next = total_q;
		if (new_spin && !site.cur) begin
			total_next = total_q + MagW'(2);
		end else if (!new_spin && site.cur) begin
			total_next = total_q - MagW'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= TotalReset;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				total_q <= total_next;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			spin_s2 <= new_spin;
			flip_s2 <= flip;
			mag_s2  <= total_next;
			done_s2 <= site.last;
		end
	end

	assign result.valid         = valid_s2;
	assign result.spin_out      = spin_s2;
	assign result.flipped       = flip_s2;
	assign result.magnetization = mag_s2;
	assign result.sweep_done    = done_s2;

endmodule
